// ===== hw/rtl/mre_pkg.sv =====
// ----------------------------------------------------------------------------
// mre_pkg: shared types and constants
// Word layouts between the front end, the dividers and the output stage of
// the Mooney-Rivlin energy evaluator, plus the output clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package mre_pkg;

  localparam int OUT_W      = 48;
  localparam int SUM_W      = 56;
  localparam int QW         = 51;
  localparam int COEF_W     = 32;
  localparam int STRETCH_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int FRONT_LAT  = 5;
  localparam int DIV_LAT    = QW + 2;
  localparam int BACK_LAT   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SECOND = 1'b1;

  localparam logic [QW:0] TERM_CAP = (QW+1)'(1) << (QW - 1);

  localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] OUT_MIN_S = ~OUT_MAX_S;

  typedef struct packed {
    logic [2:0][31:0] sq;
    logic [2:0][47:0] cube;
    logic [2:0][63:0] quart;
  } pow_t;

  typedef struct packed {
    logic [SUM_W-1:0]       e1;
    logic [2:0][SUM_W-1:0]  s1;
    logic                   zero;
  } side_t;

  typedef struct packed {
    logic [OUT_W-1:0]       energy;
    logic [2:0][OUT_W-1:0]  slope;
    logic [2:0][OUT_W-1:0]  curv;
    logic                   zero;
    logic                   sat;
  } result_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } clamp_t;

  function automatic clamp_t clamp_out(input logic signed [SUM_W-1:0] x);
    clamp_t r;
    r.sat = 1'b0;
    r.value = x[OUT_W-1:0];
    if (x > OUT_MAX_S) begin
      r.value = OUT_MAX_S[OUT_W-1:0];
      r.sat = 1'b1;
    end else if (x < OUT_MIN_S) begin
      r.value = OUT_MIN_S[OUT_W-1:0];
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mooney_rivlin_energy_eval.sv =====
// ----------------------------------------------------------------------------
// mooney_rivlin_energy_eval: two-parameter Mooney-Rivlin energy evaluator
// Energy, slopes and curvatures from three principal stretches.
// ----------------------------------------------------------------------------
// usage:
//   coefficients are written through cfg_write / cfg_index / cfg_data while
//   no word is in flight; index 0 is coef_first, index 1 coef_second
//   a stretch word is taken at each clock edge with start high and busy low;
//   busy is high only while rst is high
//   results leave on done, a one-cycle strobe, after the word has passed
//   the power and c1 terms, bit-serial pipelined division (one quotient
//   bit per stage, nine dividers) and the summing and clamping
//   throughput is one word per cycle while busy is low; the divider pipeline sets the latency
//   reset clears the coefficients and drops every word in flight
//   results cannot be held off; the receiver takes each word on its strobe
// ----------------------------------------------------------------------------
`default_nettype none

module mooney_rivlin_energy_eval #(
  parameter int STRETCH_FRAC_BITS = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [mre_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [mre_pkg::COEF_W-1:0]            cfg_data,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [mre_pkg::STRETCH_W-1:0]         stretch_a,
  input  wire logic [mre_pkg::STRETCH_W-1:0]         stretch_b,
  input  wire logic [mre_pkg::STRETCH_W-1:0]         stretch_c,
  output logic                                       done,
  output logic signed [mre_pkg::OUT_W-1:0]           energy,
  output logic signed [mre_pkg::OUT_W-1:0]           slope_a,
  output logic signed [mre_pkg::OUT_W-1:0]           slope_b,
  output logic signed [mre_pkg::OUT_W-1:0]           slope_c,
  output logic signed [mre_pkg::OUT_W-1:0]           curvature_a,
  output logic signed [mre_pkg::OUT_W-1:0]           curvature_b,
  output logic signed [mre_pkg::OUT_W-1:0]           curvature_c,
  output logic                                       zero_stretch,
  output logic                                       saturated
);

  localparam int F   = STRETCH_FRAC_BITS;
  localparam int LAT = mre_pkg::FRONT_LAT + mre_pkg::DIV_LAT + mre_pkg::BACK_LAT;
  localparam int NE_W = 32 + 2*F;
  localparam int NS_W = 33 + 3*F;
  localparam int NC_W = 35 + 4*F;

  logic signed [mre_pkg::COEF_W-1:0] coef_first, coef_second;
  logic [mre_pkg::COEF_W-1:0]        m2;
  logic [NE_W-1:0]                   num_e;
  logic [NS_W-1:0]                   num_s;
  logic [NC_W-1:0]                   num_c;

  logic [LAT-1:0] vld;

  mre_pkg::pow_t    pow;
  mre_pkg::side_t   side_f;
  mre_pkg::side_t   side_d [0:mre_pkg::DIV_LAT-1];
  mre_pkg::result_t res;

  logic [2:0][mre_pkg::QW-1:0] q_e, q_s, q_c;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_first  <= '0;
      coef_second <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mre_pkg::REG_COEF_FIRST:  coef_first  <= cfg_data;
        mre_pkg::REG_COEF_SECOND: coef_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  assign m2    = coef_second[31] ? (~coef_second + 32'd1) : coef_second;
  assign num_e = NE_W'(m2) << (2*F);
  assign num_s = NS_W'(m2) << (3*F + 1);
  assign num_c = (NC_W'(m2) << (4*F + 2)) + (NC_W'(m2) << (4*F + 1));

  mre_front #(.F(F)) u_front (
    .clk        (clk),
    .s_in       ({stretch_c, stretch_b, stretch_a}),
    .coef_first (coef_first),
    .pow        (pow),
    .side       (side_f)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    mre_div #(.NUM_W(NE_W), .DEN_W(32)) u_div_e (
      .clk (clk), .num (num_e), .den (pow.sq[i]), .quo (q_e[i])
    );
    mre_div #(.NUM_W(NS_W), .DEN_W(48)) u_div_s (
      .clk (clk), .num (num_s), .den (pow.cube[i]), .quo (q_s[i])
    );
    mre_div #(.NUM_W(NC_W), .DEN_W(64)) u_div_c (
      .clk (clk), .num (num_c), .den (pow.quart[i]), .quo (q_c[i])
    );
  end

  always_ff @(posedge clk) begin
    side_d[0] <= side_f;
    for (int k = 1; k < mre_pkg::DIV_LAT; k++) begin
      side_d[k] <= side_d[k-1];
    end
  end

  mre_back u_back (
    .clk         (clk),
    .q_e         (q_e),
    .q_s         (q_s),
    .q_c         (q_c),
    .side        (side_d[mre_pkg::DIV_LAT-1]),
    .coef_first  (coef_first),
    .coef_second (coef_second),
    .res         (res)
  );

  assign done         = vld[LAT-1];
  assign energy       = res.energy;
  assign slope_a      = res.slope[0];
  assign slope_b      = res.slope[1];
  assign slope_c      = res.slope[2];
  assign curvature_a  = res.curv[0];
  assign curvature_b  = res.curv[1];
  assign curvature_c  = res.curv[2];
  assign zero_stretch = res.zero;
  assign saturated    = res.sat;

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result word without a matching input word");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(zero_stretch && saturated))
    else $error("zero stretch and saturation both flagged");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    (done && zero_stretch) |-> (energy == '0 && slope_a == '0 && curvature_c == '0))
    else $error("zero stretch word carries nonzero results");

endmodule

`default_nettype wire

// ===== hw/rtl/mre_front.sv =====
// ----------------------------------------------------------------------------
// mre_front: stretch powers and first-coefficient terms
// Five register stages: squares, cubes, fourth powers, and the rounded c1
// parts of the energy and of the three slopes.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_front #(
  parameter int F = 14
) (
  input  wire logic                                      clk,
  input  wire logic [2:0][mre_pkg::STRETCH_W-1:0]        s_in,
  input  wire logic signed [mre_pkg::COEF_W-1:0]         coef_first,
  output mre_pkg::pow_t                                  pow,
  output mre_pkg::side_t                                 side
);

  localparam int TW = ((2*F + 2 > 34) ? 2*F + 2 : 34) + 1;
  localparam int PW = 32 + TW - 1;
  localparam int SUM_W_LOC = mre_pkg::SUM_W;
  localparam logic [TW-1:0] THREE_UNIT = TW'(3) << (2*F);
  localparam logic [49:0] HALF1 = 50'(1) << (F - 1);
  localparam logic [PW:0] HALF2 = (PW+1)'(1) << (2*F - 1);

  logic [31:0] m1;
  logic        n1;

  logic [2:0][15:0] s1, s2;
  logic [2:0][31:0] sq1, sq2, sq3, sq4;
  logic [2:0][47:0] cube2, cube3, cube4;
  logic [2:0][63:0] quart3, quart4;
  logic [TW-1:0]    tsum2;
  logic [TW-2:0]    tmag3;
  logic             tneg3, tneg4;
  logic [2:0][48:0] ps3;
  logic [2:0][49:0] psr4;
  logic [PW-1:0]    e1p4;
  logic             zero1, zero2, zero3, zero4;

  logic [PW:0]      e1r;
  logic [SUM_W_LOC-1:0] e1x;

  assign n1  = coef_first[31];
  assign m1  = n1 ? (~coef_first + 32'd1) : coef_first;
  assign e1r = ((PW+1)'(e1p4) + HALF2) >> (2*F);
  assign e1x = SUM_W_LOC'(e1r);

  always_ff @(posedge clk) begin
    zero1 <= (s_in[0] == '0) || (s_in[1] == '0) || (s_in[2] == '0);
    for (int i = 0; i < 3; i++) begin
      s1[i]  <= s_in[i];
      sq1[i] <= 32'(s_in[i]) * 32'(s_in[i]);
    end

    zero2 <= zero1;
    tsum2 <= TW'(sq1[0]) + TW'(sq1[1]) + TW'(sq1[2]) - THREE_UNIT;
    for (int i = 0; i < 3; i++) begin
      s2[i]    <= s1[i];
      sq2[i]   <= sq1[i];
      cube2[i] <= 48'(sq1[i]) * 48'(s1[i]);
    end

    zero3 <= zero2;
    tneg3 <= tsum2[TW-1];
    tmag3 <= tsum2[TW-1] ? (TW-1)'(-tsum2) : (TW-1)'(tsum2);
    for (int i = 0; i < 3; i++) begin
      sq3[i]    <= sq2[i];
      cube3[i]  <= cube2[i];
      quart3[i] <= 64'(cube2[i]) * 64'(s2[i]);
      ps3[i]    <= 49'({m1, 1'b0}) * 49'(s2[i]);
    end

    zero4 <= zero3;
    tneg4 <= tneg3;
    e1p4  <= PW'(m1) * PW'(tmag3);
    for (int i = 0; i < 3; i++) begin
      sq4[i]    <= sq3[i];
      cube4[i]  <= cube3[i];
      quart4[i] <= quart3[i];
      psr4[i]   <= ({1'b0, ps3[i]} + HALF1) >> F;
    end

    side.zero <= zero4;
    side.e1   <= (n1 ^ tneg4) ? -e1x : e1x;
    for (int i = 0; i < 3; i++) begin
      pow.sq[i]    <= sq4[i];
      pow.cube[i]  <= cube4[i];
      pow.quart[i] <= quart4[i];
      side.s1[i]   <= n1 ? -SUM_W_LOC'(psr4[i]) : SUM_W_LOC'(psr4[i]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mre_div.sv =====
// ----------------------------------------------------------------------------
// mre_div: pipelined rounding divider
// One quotient bit per stage, rounded to nearest with ties away from zero,
// result held at the term cap.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 32
) (
  input  wire logic                   clk,
  input  wire logic [NUM_W-1:0]       num,
  input  wire logic [DEN_W-1:0]       den,
  output logic [mre_pkg::QW-1:0]      quo
);

  localparam int QW = mre_pkg::QW;
  localparam int EW = NUM_W + DEN_W + QW;

  logic [EW-1:0] num_x, hi;
  logic          ov_in;

  logic [DEN_W-1:0] rem   [0:QW];
  logic [QW-1:0]    low   [0:QW];
  logic [QW-1:0]    q     [0:QW];
  logic [DEN_W-1:0] den_p [0:QW];
  logic             ov    [0:QW];

  logic             rnd;
  logic [QW:0]      qr;

  assign num_x = EW'(num);
  assign hi    = num_x >> QW;
  assign ov_in = hi >= EW'(den);

  always_ff @(posedge clk) begin
    rem[0]   <= DEN_W'(hi);
    low[0]   <= num_x[QW-1:0];
    q[0]     <= '0;
    den_p[0] <= den;
    ov[0]    <= ov_in;
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[j], low[j][QW-1]};
    assign ge    = trial >= {1'b0, den_p[j]};
    always_ff @(posedge clk) begin
      rem[j+1]   <= ge ? DEN_W'(trial - {1'b0, den_p[j]}) : DEN_W'(trial);
      low[j+1]   <= low[j] << 1;
      q[j+1]     <= {q[j][QW-2:0], ge};
      den_p[j+1] <= den_p[j];
      ov[j+1]    <= ov[j];
    end
  end

  assign rnd = {rem[QW], 1'b0} >= {1'b0, den_p[QW]};
  assign qr  = (QW+1)'(q[QW]) + (QW+1)'(rnd);

  always_ff @(posedge clk) begin
    quo <= (ov[QW] || qr > mre_pkg::TERM_CAP) ? mre_pkg::TERM_CAP[QW-1:0] : qr[QW-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mre_back.sv =====
// ----------------------------------------------------------------------------
// mre_back: term summation and output clamp
// Applies signs to the quotients, sums the energy terms over two stages,
// the others in the first, then clamps to the 48-bit range in the third.
// ----------------------------------------------------------------------------
`default_nettype none

module mre_back (
  input  wire logic                                      clk,
  input  wire logic [2:0][mre_pkg::QW-1:0]               q_e,
  input  wire logic [2:0][mre_pkg::QW-1:0]               q_s,
  input  wire logic [2:0][mre_pkg::QW-1:0]               q_c,
  input  wire mre_pkg::side_t                            side,
  input  wire logic signed [mre_pkg::COEF_W-1:0]         coef_first,
  input  wire logic signed [mre_pkg::COEF_W-1:0]         coef_second,
  output mre_pkg::result_t                               res
);

  localparam int SW = mre_pkg::SUM_W;

  logic signed [SW-1:0] c1x, c2x;
  logic                 n2;
  logic signed [SW-1:0] te [0:2];

  logic signed [SW-1:0] ea1, eb1, e2;
  logic signed [SW-1:0] sl1 [0:2];
  logic signed [SW-1:0] sl2 [0:2];
  logic signed [SW-1:0] cv1 [0:2];
  logic signed [SW-1:0] cv2 [0:2];
  logic                 zero1, zero2;

  mre_pkg::clamp_t ce;
  mre_pkg::clamp_t cs [0:2];
  mre_pkg::clamp_t cc [0:2];

  assign c1x = SW'(coef_first);
  assign c2x = SW'(coef_second);
  assign n2  = coef_second[31];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      te[i] = n2 ? -$signed(SW'(q_e[i])) : $signed(SW'(q_e[i]));
    end
  end

  always_comb begin
    ce = mre_pkg::clamp_out(e2);
    for (int i = 0; i < 3; i++) begin
      cs[i] = mre_pkg::clamp_out(sl2[i]);
      cc[i] = mre_pkg::clamp_out(cv2[i]);
    end
  end

  always_ff @(posedge clk) begin
    zero1 <= side.zero;
    ea1   <= $signed(side.e1) - ((c2x <<< 1) + c2x) + te[0];
    eb1   <= te[1] + te[2];
    for (int i = 0; i < 3; i++) begin
      sl1[i] <= $signed(side.s1[i])
              + (n2 ? $signed(SW'(q_s[i])) : -$signed(SW'(q_s[i])));
      cv1[i] <= (c1x <<< 1)
              + (n2 ? -$signed(SW'(q_c[i])) : $signed(SW'(q_c[i])));
    end

    zero2 <= zero1;
    e2    <= ea1 + eb1;
    for (int i = 0; i < 3; i++) begin
      sl2[i] <= sl1[i];
      cv2[i] <= cv1[i];
    end

    res.zero   <= zero2;
    res.energy <= zero2 ? '0 : ce.value;
    res.sat    <= !zero2 && (ce.sat || cs[0].sat || cs[1].sat || cs[2].sat
                             || cc[0].sat || cc[1].sat || cc[2].sat);
    for (int i = 0; i < 3; i++) begin
      res.slope[i] <= zero2 ? '0 : cs[i].value;
      res.curv[i]  <= zero2 ? '0 : cc[i].value;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/mre_checker.sv =====
// ----------------------------------------------------------------------------
// mre_checker: result checker for the Mooney-Rivlin energy evaluator
// Follows coefficient writes and accepted stretch words, works out the
// expected energy, slopes, curvatures and flags in exact integer arithmetic,
// and compares each done word field by field with the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mre_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mre_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mre_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              start,
  input  logic                              busy,
  input  logic [15:0]                       stretch_a,
  input  logic [15:0]                       stretch_b,
  input  logic [15:0]                       stretch_c,
  input  logic                              done,
  input  logic [47:0]                       energy,
  input  logic [47:0]                       slope_a,
  input  logic [47:0]                       slope_b,
  input  logic [47:0]                       slope_c,
  input  logic [47:0]                       curvature_a,
  input  logic [47:0]                       curvature_b,
  input  logic [47:0]                       curvature_c,
  input  logic                              zero_stretch,
  input  logic                              saturated,
  output int                                fail_count,
  output int                                pending
);

  localparam int FRAC = 14;
  localparam logic [191:0] CAP = 192'(1) << 50;
  localparam longint OMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint OMIN = -OMAX - 1;

  typedef struct {
    logic [47:0] val [7];
    logic        zero;
    logic        sat;
  } energy_word_t;

  longint coef1, coef2;
  energy_word_t expected_q [$];

  function automatic longint round_term(bit neg, logic [127:0] a, logic [127:0] b, int e,
                                        logic [127:0] d);
    logic [191:0] num, q, r;
    num = ({64'b0, a} * {64'b0, b}) << e;
    q = num / {64'b0, d};
    r = num % {64'b0, d};
    if (q >= CAP) q = CAP;
    else if (r >= {64'b0, d} - r) q = q + 1;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [47:0] clamp48(longint v, inout logic sat);
    if (v > OMAX) begin
      v = OMAX;
      sat = 1'b1;
    end
    if (v < OMIN) begin
      v = OMIN;
      sat = 1'b1;
    end
    return v[47:0];
  endfunction

  function automatic energy_word_t predict_energy(logic [15:0] sa, logic [15:0] sb,
                                                  logic [15:0] sc);
    energy_word_t w;
    logic [63:0] s [3];
    logic [127:0] s2, s3, s4;
    longint sumsq, en, sl, cv;
    logic [63:0] m1, m2, msum;
    bit n1, n2;
    w.sat = 1'b0;
    w.zero = 1'b0;
    s[0] = sa;
    s[1] = sb;
    s[2] = sc;
    for (int i = 0; i < 7; i++) w.val[i] = '0;
    if (sa == 0 || sb == 0 || sc == 0) begin
      w.zero = 1'b1;
      return w;
    end
    n1 = coef1 < 0;
    n2 = coef2 < 0;
    m1 = n1 ? -coef1 : coef1;
    m2 = n2 ? -coef2 : coef2;
    sumsq = longint'(s[0] * s[0] + s[1] * s[1] + s[2] * s[2]) - 3 * (longint'(1) << (2 * FRAC));
    msum = sumsq < 0 ? -sumsq : sumsq;
    en = round_term(n1 != (sumsq < 0), m1, msum, 0, 128'(1) << (2 * FRAC)) - 3 * coef2;
    for (int i = 0; i < 3; i++) begin
      s2 = s[i] * s[i];
      s3 = s2 * s[i];
      s4 = s3 * s[i];
      en += round_term(n2, m2, 1, 2 * FRAC, s2);
      sl = round_term(n1, 2 * m1, s[i], 0, 128'(1) << FRAC)
         + round_term(!n2, 2 * m2, 1, 3 * FRAC, s3);
      cv = 2 * coef1 + round_term(n2, 6 * m2, 1, 4 * FRAC, s4);
      w.val[1 + i] = clamp48(sl, w.sat);
      w.val[4 + i] = clamp48(cv, w.sat);
    end
    w.val[0] = clamp48(en, w.sat);
    return w;
  endfunction

  always @(posedge clk) begin
    energy_word_t exp_w;
    logic [47:0] got [7];
    if (rst) begin
      coef1 <= 0;
      coef2 <= 0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == mre_pkg::REG_COEF_FIRST) coef1 <= longint'($signed(cfg_data));
        else if (cfg_index == mre_pkg::REG_COEF_SECOND) coef2 <= longint'($signed(cfg_data));
      end
      if (start && !busy) expected_q.push_back(predict_energy(stretch_a, stretch_b, stretch_c));
      if (done) begin
        got = '{energy, slope_a, slope_b, slope_c, curvature_a, curvature_b, curvature_c};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result word", $time);
          fail_count++;
        end else begin
          exp_w = expected_q.pop_front();
          for (int i = 0; i < 7; i++)
            if (got[i] !== exp_w.val[i]) begin
              $display("%0t: field %0d expected %h got %h", $time, i, exp_w.val[i], got[i]);
              fail_count++;
            end
          if (zero_stretch !== exp_w.zero) begin
            $display("%0t: zero_stretch expected %b got %b", $time, exp_w.zero, zero_stretch);
            fail_count++;
          end
          if (saturated !== exp_w.sat) begin
            $display("%0t: saturated expected %b got %b", $time, exp_w.sat, saturated);
            fail_count++;
          end
        end
      end
    end
  end

  assign pending = expected_q.size();

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for mooney_rivlin_energy_eval
// Runs several coefficient settings with random stretch words under varying
// sender gaps, and directed words for one; the checker compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [mre_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic start = 0;
  logic [15:0] stretch_a = 16'h4000, stretch_b = 16'h4000, stretch_c = 16'h4000;
  logic busy, done, zero_stretch, saturated;
  logic signed [47:0] energy, slope_a, slope_b, slope_c;
  logic signed [47:0] curvature_a, curvature_b, curvature_c;
  int fail_count, pending, quiet_cycles;
  int idle_pct;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  mooney_rivlin_energy_eval DUT (.*);

  mre_checker checker_i (.*);

  always @(posedge clk) begin
    if ((start && !busy) || done || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 4000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_coef(logic [mre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 0;
  endtask

  task automatic send_word(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    if ($urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start = 1;
    stretch_a = a;
    stretch_b = b;
    stretch_c = c;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_stretch();
    case ($urandom_range(9))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom);
      2: return 16'($urandom_range(65535 - 255, 65535));
      3: return 16'($urandom_range(0, 3)) == 0 ? 16'd0 : 16'($urandom);
      default: return 16'($urandom_range(12000, 24000));
    endcase
  endfunction

  task automatic drain();
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  logic [31:0] c1_set [8];
  logic [31:0] c2_set [8];

  initial begin
    c1_set = '{32'h0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0000_8000, 32'($urandom), 32'hFFFF_0000};
    c2_set = '{32'h0, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'hFFFF_C000, 32'($urandom), 32'h0003_0000};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    idle_pct = 0;
    for (int p = 0; p < 8; p++) begin
      write_coef(mre_pkg::REG_COEF_FIRST, c1_set[p]);
      write_coef(mre_pkg::REG_COEF_SECOND, c2_set[p]);
      if (p == 1) begin
        send_word(16'h4000, 16'h4000, 16'h4000);
        send_word(16'd1, 16'd1, 16'd1);
        send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(16'd0, 16'h4000, 16'h4000);
        send_word(16'h4000, 16'd0, 16'h4000);
        send_word(16'h4000, 16'h4000, 16'd0);
        send_word(16'd0, 16'd0, 16'd0);
        send_word(16'd1, 16'hFFFF, 16'h4000);
        send_word(16'h8000, 16'h2000, 16'h4000);
        send_word(16'hAAAA, 16'h5555, 16'h0001);
        send_word(16'h5555, 16'hAAAA, 16'hFFFE);
        drain();
      end
      idle_pct = (p % 4 == 1) ? 60 : (p % 4 == 3) ? 30 : 0;
      for (int i = 0; i < 150; i++) begin
        send_word(rand_stretch(), rand_stretch(), rand_stretch());
        if (i == 75 && p % 2 == 0) idle_pct = 60 - idle_pct;
      end
      drain();
    end
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mre_pkg.sv
hw/rtl/mre_front.sv
hw/rtl/mre_div.sv
hw/rtl/mre_back.sv
hw/rtl/mooney_rivlin_energy_eval.sv
tb/sv/mre_checker.sv
tb/sv/tb_top.sv
